// File: hdl/ttoi_pkg.sv
// ----------------------------------------------------------------------------
// ttoi_pkg: shared types and constants of the text-to-integer parser
// Phase encoding, controller/datapath command and status structs,
// character codes and the digit decoder.
// ----------------------------------------------------------------------------
package ttoi_pkg;

  localparam int CH_WIDTH        = 8;
  localparam int BASE_WIDTH      = 6;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 6;
  localparam int OUT_VALUE_WIDTH = 64;
  localparam int OUT_POS_WIDTH   = 16;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NUMBER_BASE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIGNED_MODE = 1'd1;

  // radix values
  localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_WIDTH-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_WIDTH-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_MAX  = 6'd36;

  // character codes
  localparam logic [CH_WIDTH-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_WIDTH-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_WIDTH-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_WIDTH-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_WIDTH-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_WIDTH-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_WIDTH-1:0] CH_NINE   = 8'h39;
  localparam logic [CH_WIDTH-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CH_WIDTH-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CH_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CH_WIDTH-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_WIDTH-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CH_WIDTH-1:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_PREFIX,
    PH_ZERO,
    PH_ZEROX,
    PH_DIGITS,
    PH_DONE,
    PH_FLUSH
  } phase_t;

  typedef struct packed {
    logic                  valid;
    logic [BASE_WIDTH-1:0] value;
  } digit_t;

  // controller to datapath
  typedef struct packed {
    logic                  neg;    // load sign from a minus
    logic                  bump;   // count one consumed character
    logic                  mark;   // digit seen, end offset at new count
    logic                  take;   // accumulate digit in base
    logic                  set_bad;
    logic                  emit;   // load result register, clear string
    logic [BASE_WIDTH-1:0] base;
    logic [BASE_WIDTH-1:0] digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic digit_t digit_of(input logic [CH_WIDTH-1:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.value = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d.value = BASE_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d.value = BASE_WIDTH'(c - CH_LOWER_A) + BASE_DEC;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d.value = BASE_WIDTH'(c - CH_UPPER_A) + BASE_DEC;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: hdl/ttoi_ifs.sv
// ----------------------------------------------------------------------------
// ttoi_in_if / ttoi_out_if: character and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ttoi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ttoi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] end_offset;
  logic        converted;
  logic        overflowed;
  logic        bad_base;

  modport source (output valid, output value, output end_offset, output converted,
                  output overflowed, output bad_base, input ready);
  modport sink   (input valid, input value, input end_offset, input converted,
                  input overflowed, input bad_base, output ready);
endinterface

// File: hdl/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser: streaming ASCII to integer converter
// Skips whitespace, takes a sign and radix prefix and accumulates digits
// in radix 2..36 with signed or unsigned saturation.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | beat
//  in_bus   | in  | ch[7:0], last                                | one character
//  out_bus  | out | value[63:0], end_offset[15:0], converted,    | one per string
//           |     | overflowed, bad_base                         |
//  cfg_*    | in  | cfg_index[0], cfg_data[5:0]                  | write on cfg_we
//
// One character beat per cycle while in_bus.ready is high; the multiply-accumulate
// and limit compare of the datapath are combinational into the accumulator.
// A beat with last is followed by a flush phase in which the result register loads;
// in_bus.ready is low during it, and it waits while the result register is
// still full.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module text_to_integer_parser #(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  ttoi_in_if.sink                                  in_bus,
  ttoi_out_if.source                               out_bus,
  input  logic                                     cfg_we,
  input  logic [ttoi_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [ttoi_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

  logic [ttoi_pkg::BASE_WIDTH-1:0] number_base_r;
  logic                            signed_mode_r;
  ttoi_pkg::cmd_t                  cmd;
  ttoi_pkg::stat_t                 stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= ttoi_pkg::BASE_DEC;
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ttoi_pkg::REG_NUMBER_BASE: number_base_r <= cfg_data;
        ttoi_pkg::REG_SIGNED_MODE: signed_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ttoi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .number_base (number_base_r),
    .stat        (stat),
    .cmd         (cmd)
  );

  ttoi_dp #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .signed_mode (signed_mode_r),
    .stat        (stat),
    .out_bus     (out_bus)
  );

  // result loads only into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_bus.valid || out_bus.ready))
    else $error("result loaded over a pending beat");

  // a new result beat appears only after a load
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(cmd.emit))
    else $error("result valid without a load");

  // no character is taken while the result is loaded
  a_emit_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_bus.ready)
    else $error("character accepted during result load");

endmodule

// File: hdl/ttoi_ctrl.sv
// ----------------------------------------------------------------------------
// ttoi_ctrl: parse controller
// Tracks the parse phase and the active radix, classifies each character
// beat and issues commands to the datapath.
// ----------------------------------------------------------------------------
module ttoi_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  ttoi_in_if.sink                             in_bus,
  input  logic [ttoi_pkg::BASE_WIDTH-1:0]     number_base,
  input  ttoi_pkg::stat_t                     stat,
  output ttoi_pkg::cmd_t                      cmd
);

  ttoi_pkg::phase_t                      state_r, state_nxt;
  logic [ttoi_pkg::BASE_WIDTH-1:0]       base_r, base_nxt;

  ttoi_pkg::phase_t                      wk_phase;
  logic [ttoi_pkg::BASE_WIDTH-1:0]       wk_base;
  logic                                  wk_bump, wk_neg, wk_mark, wk_take, wk_bad;
  ttoi_pkg::digit_t                      dig;
  logic                                  is_ws, is_sign, is_x, cfg_bad, accept;

  // classify the incoming character
  assign dig     = ttoi_pkg::digit_of(in_bus.ch);
  assign is_ws   = (in_bus.ch == ttoi_pkg::CH_SPACE) ||
                   (in_bus.ch >= ttoi_pkg::CH_TAB && in_bus.ch <= ttoi_pkg::CH_CR);
  assign is_sign = (in_bus.ch == ttoi_pkg::CH_PLUS) || (in_bus.ch == ttoi_pkg::CH_MINUS);
  assign is_x    = (in_bus.ch == ttoi_pkg::CH_LOWER_X) || (in_bus.ch == ttoi_pkg::CH_UPPER_X);
  assign cfg_bad = (number_base == ttoi_pkg::BASE_ONE) || (number_base > ttoi_pkg::BASE_MAX);

  assign in_bus.ready = (state_r != ttoi_pkg::PH_FLUSH);
  assign accept       = in_bus.valid && in_bus.ready;

  // walk the phases a character passes through in one beat
  always_comb begin : walk
    ttoi_pkg::phase_t ph;
    ph       = state_r;
    wk_phase = state_r;
    wk_base  = base_r;
    wk_bump  = 1'b0;
    wk_neg   = 1'b0;
    wk_mark  = 1'b0;
    wk_take  = 1'b0;
    wk_bad   = 1'b0;
    if (ph == ttoi_pkg::PH_SKIP) begin
      if (is_ws) begin
        wk_bump = 1'b1;
      end else if (is_sign) begin
        wk_neg   = (in_bus.ch == ttoi_pkg::CH_MINUS);
        wk_bump  = 1'b1;
        wk_phase = ttoi_pkg::PH_PREFIX;
      end else begin
        ph = ttoi_pkg::PH_PREFIX;
      end
    end
    if (ph == ttoi_pkg::PH_PREFIX) begin
      if (cfg_bad) begin
        wk_bad   = 1'b1;
        wk_phase = ttoi_pkg::PH_DONE;
      end else if ((number_base == ttoi_pkg::BASE_AUTO || number_base == ttoi_pkg::BASE_HEX)
                   && in_bus.ch == ttoi_pkg::CH_ZERO) begin
        wk_mark  = 1'b1;
        wk_base  = number_base;
        wk_phase = ttoi_pkg::PH_ZERO;
      end else begin
        wk_base = (number_base == ttoi_pkg::BASE_AUTO) ? ttoi_pkg::BASE_DEC : number_base;
        ph      = ttoi_pkg::PH_DIGITS;
      end
    end
    if (ph == ttoi_pkg::PH_ZERO) begin
      if (is_x) begin
        wk_bump  = 1'b1;
        wk_phase = ttoi_pkg::PH_ZEROX;
      end else begin
        wk_base = (wk_base == ttoi_pkg::BASE_AUTO) ? ttoi_pkg::BASE_OCT : ttoi_pkg::BASE_HEX;
        ph      = ttoi_pkg::PH_DIGITS;
      end
    end
    if (ph == ttoi_pkg::PH_ZEROX) begin
      wk_base = ttoi_pkg::BASE_HEX;
      if (dig.valid && dig.value < ttoi_pkg::BASE_HEX) begin
        ph = ttoi_pkg::PH_DIGITS;
      end else begin
        wk_phase = ttoi_pkg::PH_DONE;
      end
    end
    if (ph == ttoi_pkg::PH_DIGITS) begin
      if (dig.valid && dig.value < wk_base && wk_base >= ttoi_pkg::BASE_MIN) begin
        wk_take  = 1'b1;
        wk_phase = ttoi_pkg::PH_DIGITS;
      end else begin
        wk_phase = ttoi_pkg::PH_DONE;
      end
    end
  end

  // next phase and active radix
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    if (state_r == ttoi_pkg::PH_FLUSH) begin
      if (stat.out_free) begin
        state_nxt = ttoi_pkg::PH_SKIP;
        base_nxt  = '0;
      end
    end else if (accept) begin
      state_nxt = in_bus.last ? ttoi_pkg::PH_FLUSH : wk_phase;
      base_nxt  = wk_base;
    end
  end

  // commands to the datapath
  always_comb begin
    cmd       = '0;
    cmd.base  = wk_base;
    cmd.digit = dig.value;
    if (accept) begin
      cmd.neg     = wk_neg;
      cmd.bump    = wk_bump || wk_mark || wk_take;
      cmd.mark    = wk_mark || wk_take;
      cmd.take    = wk_take;
      // an end of string still in the whitespace or sign phase sees the bad radix too
      cmd.set_bad = wk_bad || (in_bus.last && cfg_bad &&
                    (wk_phase == ttoi_pkg::PH_SKIP || wk_phase == ttoi_pkg::PH_PREFIX));
    end
    cmd.emit = (state_r == ttoi_pkg::PH_FLUSH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttoi_pkg::PH_SKIP;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

// File: hdl/ttoi_dp.sv
// ----------------------------------------------------------------------------
// ttoi_dp: accumulate datapath and result register
// Multiply-accumulates digits with a limit check, counts consumed
// characters and forms the result beat.
// ----------------------------------------------------------------------------
module ttoi_dp #(
  parameter int VALUE_WIDTH    = 64,
  parameter int POSITION_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ttoi_pkg::cmd_t   cmd,
  input  logic             signed_mode,
  output ttoi_pkg::stat_t  stat,
  ttoi_out_if.source       out_bus
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = POSITION_WIDTH;
  localparam int BW = ttoi_pkg::BASE_WIDTH;
  localparam int OW = ttoi_pkg::OUT_VALUE_WIDTH;
  localparam int OP = ttoi_pkg::OUT_POS_WIDTH;

  logic [VW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic          sat_r, sat_nxt;
  logic          seen_r, seen_nxt;
  logic          bad_r, bad_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] stop_r, stop_nxt;
  logic          out_valid_r;

  logic [OW-1:0] value_r;
  logic [OP-1:0] end_r;
  logic          conv_r, ovf_r, badb_r;

  logic [VW-1:0]   lim, acc_neg, res_v;
  logic [VW+BW-1:0] prod;
  logic [VW+BW:0]   sum;
  logic            over;
  logic [PW-1:0]   cnt_inc;
  logic [VW+OW-1:0] v_ext;
  logic [PW+OP-1:0] stop_ext;
  logic            res_ok;

  // limit for the current sign and mode
  always_comb begin
    if (signed_mode) begin
      lim = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      lim = '1;
    end
  end

  // multiply-accumulate and overflow compare
  assign prod = {{BW{1'b0}}, acc_r} * {{VW{1'b0}}, cmd.base};
  assign sum  = {1'b0, prod} + {{(VW+1){1'b0}}, cmd.digit};
  assign over = sum > {{(BW+1){1'b0}}, lim};

  // hold the count at its maximum
  assign cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    acc_nxt  = acc_r;
    neg_nxt  = neg_r || cmd.neg;
    sat_nxt  = sat_r;
    seen_nxt = seen_r || cmd.mark;
    bad_nxt  = bad_r || cmd.set_bad;
    cnt_nxt  = cmd.bump ? cnt_inc : cnt_r;
    stop_nxt = cmd.mark ? cnt_inc : stop_r;
    if (cmd.take) begin
      if (over) begin
        sat_nxt = 1'b1;
        acc_nxt = lim;
      end else if (!sat_r) begin
        acc_nxt = sum[VW-1:0];
      end
    end
    // drop the string state once the result is loaded
    if (cmd.emit) begin
      acc_nxt  = '0;
      neg_nxt  = 1'b0;
      sat_nxt  = 1'b0;
      seen_nxt = 1'b0;
      bad_nxt  = 1'b0;
      cnt_nxt  = '0;
      stop_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      neg_r  <= 1'b0;
      sat_r  <= 1'b0;
      seen_r <= 1'b0;
      bad_r  <= 1'b0;
      cnt_r  <= '0;
      stop_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      sat_r  <= sat_nxt;
      seen_r <= seen_nxt;
      bad_r  <= bad_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

  // form the result: saturated, negated or plain
  assign acc_neg = ~acc_r + {{(VW-1){1'b0}}, 1'b1};
  always_comb begin
    if (sat_r) begin
      res_v = signed_mode ? acc_r : '1;
    end else begin
      res_v = neg_r ? acc_neg : acc_r;
    end
  end
  assign res_ok   = seen_r && !bad_r;
  assign v_ext    = {{OW{1'b0}}, res_v};
  assign stop_ext = {{OP{1'b0}}, stop_r};

  // result register: load on emit, release on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      value_r <= res_ok ? v_ext[OW-1:0] : '0;
      end_r   <= res_ok ? stop_ext[OP-1:0] : '0;
      conv_r  <= res_ok;
      ovf_r   <= res_ok && sat_r;
      badb_r  <= bad_r;
    end
  end

  assign stat.out_free      = !out_valid_r || out_bus.ready;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.value      = value_r;
  assign out_bus.end_offset = end_r;
  assign out_bus.converted  = conv_r;
  assign out_bus.overflowed = ovf_r;
  assign out_bus.bad_base   = badb_r;

endmodule
